// ===== rtl/rpsw_pkg.sv =====
// ----------------------------------------------------------------------------
// rpsw_pkg: shared types and constants of the RGB pair support weight unit
// Register indexes, field widths, controller states and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rpsw_pkg;

    localparam int PIXEL_W     = 8;
    localparam int COORD_W     = 10;
    localparam int WEIGHT_W    = 8;
    localparam int DISTANCE_W  = 6;
    localparam int WIDTH_W     = 11;
    localparam int THRESHOLD_W = 8;
    localparam int STEP_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP      = 3'd4;

    localparam logic                   RST_DIRECTION = 1'b0;
    localparam logic [DISTANCE_W-1:0]  RST_DISTANCE  = 6'd1;
    localparam logic [WIDTH_W-1:0]     RST_WIDTH     = 11'd640;
    localparam logic [THRESHOLD_W-1:0] RST_THRESHOLD = 8'd32;
    localparam logic [STEP_W-1:0]      RST_STEP      = 8'd16;

    localparam logic [7:0] FULL_SCALE = 8'hFF;
    localparam logic [7:0] ROUND_BIAS = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE_WAIT,
        ST_MUL,
        ST_DELAY,
        ST_READ,
        ST_SAD,
        ST_WSCALE,
        ST_WEIGHT,
        ST_DIV_WAIT,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic in_ready;
        logic div_start_scale;
        logic load_scale;
        logic load_mul;
        logic load_delay;
        logic issue_read;
        logic load_sad;
        logic div_start_pos;
        logic load_scaled;
        logic load_weight;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic scale_ok;
        logic hit;
        logic vertical;
        logic div_busy;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/rpsw_stream_if.sv =====
// ----------------------------------------------------------------------------
// rpsw_stream_if: pixel and result channels
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface rpsw_pixel_if;
    import rpsw_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] red;
    logic [PIXEL_W-1:0] green;
    logic [PIXEL_W-1:0] blue;
    logic               frame_start;

    modport source (output valid, output red, output green, output blue,
                    output frame_start, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_start, output ready);
endinterface

interface rpsw_result_if;
    import rpsw_pkg::*;

    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] weight;
    logic [COORD_W-1:0]  out_column;
    logic [COORD_W-1:0]  out_row;

    modport source (output valid, output weight, output out_column, output out_row,
                    input ready);
    modport sink   (input valid, input weight, input out_column, input out_row,
                    output ready);
endinterface

// ===== rtl/rpsw_ram.sv =====
// ----------------------------------------------------------------------------
// rpsw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rpsw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/rpsw_div.sv =====
// ----------------------------------------------------------------------------
// rpsw_div: restoring divider
// One quotient bit per cycle; a division yields DIVIDEND_W quotient bits.
// ----------------------------------------------------------------------------
module rpsw_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        diff     = shifted - {1'b0, dvs_reg};
        // Without a subtraction the shifted remainder is below the divisor.
        rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && !done_reg))
        else $error("divider did not start a division");
endmodule

// ===== rtl/rpsw_datapath.sv =====
// ----------------------------------------------------------------------------
// rpsw_datapath: position tracking, delay store and weight arithmetic
// Holds the configuration registers, counters, delay RAM, divider and the
// output register; every step is launched by a command from the controller.
// ----------------------------------------------------------------------------
module rpsw_datapath #(
    parameter int DELAY_DEPTH = 16384,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rpsw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rpsw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  rpsw_pkg::cmd_t                   cmd,
    output rpsw_pkg::status_t                status,
    rpsw_pixel_if.sink                       pixel,
    rpsw_result_if.source                    result
);
    import rpsw_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int DW  = $clog2(DELAY_DEPTH + 1);
    localparam int RPW = RW + WW;
    localparam int LW  = RW + WW + 1;
    localparam int XW  = (LW > DW) ? LW : DW;
    localparam int DVW = (WW > 8) ? WW : 8;
    localparam int HCW = (CW > DISTANCE_W) ? CW : DISTANCE_W;
    localparam int PDW = DISTANCE_W + WW;
    localparam int PXW = 3 * PIXEL_W;

    // Configuration registers.
    logic                   direction_reg;
    logic [DISTANCE_W-1:0]  distance_reg;
    logic [WIDTH_W-1:0]     width_reg;
    logic [THRESHOLD_W-1:0] threshold_reg;
    logic [STEP_W-1:0]      step_reg;

    // Control state.
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic          scale_valid_reg;
    logic          out_valid_reg;

    // Per-word working registers.
    logic [PXW-1:0]         pix_reg;
    logic [PDW-1:0]         delay_prod_reg;
    logic [RPW-1:0]         row_prod_reg;
    logic [DW-1:0]          delay_reg, delay_next;
    logic [LW-1:0]          lin_reg;
    logic [7:0]             cd_reg;
    logic                   hit_reg, hit_next;
    logic [LW-1:0]          e_reg, e_next;
    logic [HCW-1:0]         hcol_reg, hcol_next;
    logic [RW-1:0]          hrow_reg;
    logic [THRESHOLD_W-1:0] inv_reg, inv_next;
    logic [7:0]             scaled_reg;
    logic [WEIGHT_W-1:0]    weight_reg, weight_next;
    logic [7:0]             scale_reg;
    logic [THRESHOLD_W-1:0] scale_thr_reg;
    logic [WEIGHT_W-1:0]    out_weight_reg;
    logic [COORD_W-1:0]     out_col_reg, out_col_next;
    logic [COORD_W-1:0]     out_row_reg, out_row_next;

    logic                   vertical;
    logic                   accept;
    logic                   out_free;
    logic [WW-1:0]          w_eff;
    logic [THRESHOLD_W-1:0] thr_eff;

    logic [DW:0]            wp_ext, dl_ext, rd_ext;
    logic [AW-1:0]          rd_addr;
    logic [PXW-1:0]         ram_rdata;
    logic [PXW-1:0]         partner;
    logic [PIXEL_W+1:0]     sad;
    logic [THRESHOLD_W-1:0] sat;
    logic [CW:0]            col_inc;
    logic [RW:0]            row_inc;
    logic [15:0]            weight_prod;

    logic                   div_start;
    logic [LW-1:0]          div_dividend;
    logic [DVW-1:0]         div_divisor;
    logic                   div_busy;
    logic                   div_done;
    logic [LW-1:0]          div_quo;
    logic [DVW-1:0]         div_rem;

    logic [COORD_W+DVW-1:0] rem_ext;
    logic [COORD_W+LW-1:0]  quo_ext;
    logic [COORD_W+HCW-1:0] hcol_ext;
    logic [COORD_W+RW-1:0]  hrow_ext;

    function automatic logic [PIXEL_W-1:0] absdiff(input logic [PIXEL_W-1:0] a,
                                                   input logic [PIXEL_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign vertical = (direction_reg == 1'b0);
    assign accept   = pixel.valid & cmd.in_ready;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        thr_eff = (threshold_reg == '0) ? THRESHOLD_W'(1) : threshold_reg;
    end

    // The partner sits delay entries behind the write pointer, modulo the depth.
    always_comb
    begin
        wp_ext = (DW + 1)'(wp_reg);
        dl_ext = (DW + 1)'(delay_reg);
        if (wp_ext >= dl_ext)
        begin
            rd_ext = wp_ext - dl_ext;
        end
        else
        begin
            rd_ext = wp_ext + (DW + 1)'(DELAY_DEPTH) - dl_ext;
        end
        rd_addr = rd_ext[AW-1:0];
    end

    always_comb
    begin
        // Vertical delays are clamped to the store depth; the horizontal delay
        // is the distance itself and is not clamped.
        if (vertical)
        begin
            delay_next = (delay_prod_reg > PDW'(DELAY_DEPTH)) ? DW'(DELAY_DEPTH)
                                                               : DW'(delay_prod_reg);
        end
        else
        begin
            delay_next = DW'(distance_reg);
        end

        e_next    = LW'(XW'(lin_reg) - XW'(delay_reg));
        hcol_next = HCW'(col_reg) - HCW'(distance_reg);
        hit_next  = vertical ? (XW'(lin_reg) >= XW'(delay_reg))
                             : (HCW'(col_reg) >= HCW'(distance_reg));

        partner = (delay_reg == '0) ? pix_reg : ram_rdata;
        sad = (PIXEL_W + 2)'(absdiff(partner[PIXEL_W-1:0], pix_reg[PIXEL_W-1:0]))
            + (PIXEL_W + 2)'(absdiff(partner[2*PIXEL_W-1:PIXEL_W],
                                     pix_reg[2*PIXEL_W-1:PIXEL_W]))
            + (PIXEL_W + 2)'(absdiff(partner[PXW-1:2*PIXEL_W],
                                     pix_reg[PXW-1:2*PIXEL_W]));
        sat      = (sad > (PIXEL_W + 2)'(thr_eff)) ? thr_eff : sad[THRESHOLD_W-1:0];
        inv_next = thr_eff - sat;

        weight_prod = 16'(scaled_reg) * 16'(cd_reg)
                    + (vertical ? 16'(ROUND_BIAS) : 16'd0);
        weight_next = weight_prod[15:8];

        col_inc = (CW + 1)'(col_reg) + (CW + 1)'(1);
        row_inc = (RW + 1)'(row_reg) + (RW + 1)'(1);
        if (col_inc >= (CW + 1)'(w_eff))
        begin
            col_next = '0;
            row_next = (row_inc >= (RW + 1)'(MAX_HEIGHT)) ? '0 : row_inc[RW-1:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_reg;
        end
        wp_next = (int'(wp_reg) == DELAY_DEPTH - 1) ? '0 : wp_reg + AW'(1);

        rem_ext  = {{COORD_W{1'b0}}, div_rem};
        quo_ext  = {{COORD_W{1'b0}}, div_quo};
        hcol_ext = {{COORD_W{1'b0}}, hcol_reg};
        hrow_ext = {{COORD_W{1'b0}}, hrow_reg};
        out_col_next = vertical ? rem_ext[COORD_W-1:0] : hcol_ext[COORD_W-1:0];
        out_row_next = vertical ? quo_ext[COORD_W-1:0] : hrow_ext[COORD_W-1:0];
    end

    assign div_start    = cmd.div_start_scale | cmd.div_start_pos;
    assign div_dividend = cmd.div_start_pos ? e_reg : LW'(FULL_SCALE);
    assign div_divisor  = cmd.div_start_pos ? DVW'(w_eff) : DVW'(thr_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= RST_DIRECTION;
            distance_reg  <= RST_DISTANCE;
            width_reg     <= RST_WIDTH;
            threshold_reg <= RST_THRESHOLD;
            step_reg      <= RST_STEP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DIRECTION: direction_reg <= cfg_data[0];
                CFG_DISTANCE:  distance_reg  <= cfg_data[DISTANCE_W-1:0];
                CFG_WIDTH:     width_reg     <= cfg_data[WIDTH_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[THRESHOLD_W-1:0];
                CFG_STEP:      step_reg      <= cfg_data[STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            wp_reg          <= '0;
            scale_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept && pixel.frame_start)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.load_sad)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cmd.load_sad)
            begin
                wp_reg <= wp_next;
            end
            if (cmd.div_start_scale)
            begin
                scale_valid_reg <= 1'b0;
            end
            else if (cmd.load_scale)
            begin
                scale_valid_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= {pixel.blue, pixel.green, pixel.red};
        end
        if (cmd.load_mul)
        begin
            delay_prod_reg <= PDW'(distance_reg) * PDW'(w_eff);
            row_prod_reg   <= RPW'(row_reg) * RPW'(w_eff);
        end
        if (cmd.load_delay)
        begin
            delay_reg <= delay_next;
            lin_reg   <= LW'(row_prod_reg) + LW'(col_reg);
            cd_reg    <= FULL_SCALE - 8'(14'(distance_reg) * 14'(step_reg));
        end
        if (cmd.issue_read)
        begin
            hit_reg  <= hit_next;
            e_reg    <= e_next;
            hcol_reg <= hcol_next;
            hrow_reg <= row_reg;
        end
        if (cmd.load_sad)
        begin
            inv_reg <= inv_next;
        end
        if (cmd.load_scaled)
        begin
            scaled_reg <= 8'(16'(inv_reg) * 16'(scale_reg));
        end
        if (cmd.load_weight)
        begin
            weight_reg <= weight_next;
        end
        if (cmd.div_start_scale)
        begin
            scale_thr_reg <= thr_eff;
        end
        if (cmd.load_scale)
        begin
            scale_reg <= 8'(div_quo);
        end
        if (cmd.emit)
        begin
            out_weight_reg <= weight_reg;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
        end
    end

    rpsw_ram #(
        .WIDTH (PXW),
        .DEPTH (DELAY_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load_sad),
        .waddr (wp_reg),
        .wdata (pix_reg),
        .re    (cmd.issue_read),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    rpsw_div #(
        .DIVIDEND_W (LW),
        .DIVISOR_W  (DVW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign pixel.ready       = cmd.in_ready;
    assign result.valid      = out_valid_reg;
    assign result.weight     = out_weight_reg;
    assign result.out_column = out_col_reg;
    assign result.out_row    = out_row_reg;

    assign status.in_valid = pixel.valid;
    assign status.scale_ok = scale_valid_reg && (scale_thr_reg == thr_eff);
    assign status.hit      = hit_reg;
    assign status.vertical = vertical;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || result.ready))
        else $error("result overwritten while still pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_sad |-> $past(cmd.issue_read))
        else $error("delay store data used without a read in the cycle before");
endmodule

// ===== rtl/rpsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpsw_ctrl: sequencer of the RGB pair support weight unit
// Steps one word at a time through multiply, delay, read, difference,
// scaling and weighting, then, for a word with a partner, optional position division and output.
// ----------------------------------------------------------------------------
module rpsw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  rpsw_pkg::status_t   status,
    output rpsw_pkg::cmd_t      cmd
);
    import rpsw_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!status.scale_ok)
                begin
                    state_next = ST_SCALE_WAIT;
                end
                else if (status.in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_SCALE_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:     state_next = ST_DELAY;
            ST_DELAY:   state_next = ST_READ;
            ST_READ:    state_next = ST_SAD;
            ST_SAD:     state_next = ST_WSCALE;
            ST_WSCALE:  state_next = ST_WEIGHT;
            ST_WEIGHT:
            begin
                if (!status.hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.vertical)
                begin
                    state_next = ST_DIV_WAIT;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready        = status.scale_ok;
                cmd.div_start_scale = !status.scale_ok;
            end
            ST_SCALE_WAIT: cmd.load_scale  = status.div_done;
            ST_MUL:        cmd.load_mul    = 1'b1;
            ST_DELAY:      cmd.load_delay  = 1'b1;
            ST_READ:       cmd.issue_read  = 1'b1;
            ST_SAD:
            begin
                cmd.load_sad      = 1'b1;
                // The row and column division runs alongside the weight math.
                cmd.div_start_pos = status.hit && status.vertical;
            end
            ST_WSCALE:     cmd.load_scaled = 1'b1;
            ST_WEIGHT:     cmd.load_weight = 1'b1;
            ST_DIV_WAIT:   ;
            ST_EMIT:       cmd.emit        = status.out_free;
            default:       ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && cmd.in_ready && status.in_valid) |=> state_reg == ST_MUL)
        else $error("accepted word did not enter the multiply step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start_scale || cmd.div_start_pos) |-> !status.div_busy)
        else $error("divider started while busy");
endmodule

// ===== rtl/rgb_pair_support_weight_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_pair_support_weight_unit: RGB pair support weight unit
// Pairs each pixel with the one delta rows or columns earlier and emits the
// adaptive support weight tagged with the earlier pixel's position.
//
//   channel   direction  handshake     payload
//   pixel     in         valid/ready   red, green, blue, frame_start
//   result    out        valid/ready   weight, out_column, out_row
//   cfg       in         cfg_write     cfg_index, cfg_data
//
// One word is in work at a time. In vertical mode a word with a partner
// also waits for the bit-serial row/column divider, whose dividend has
// LW = clog2(MAX_HEIGHT) + clog2(MAX_WIDTH + 1) + 1 bits; a word without
// a partner gives no result. After reset and after a threshold change a
// scale division runs before the next word is taken. A stalled result
// holds the sequencer in its output step; the next word may still be
// accepted while a result waits. Reset is asynchronous and active low.
// ----------------------------------------------------------------------------
module rgb_pair_support_weight_unit #(
    parameter int DELAY_DEPTH = 16384,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rpsw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rpsw_pkg::CFG_DATA_W-1:0]  cfg_data,
    rpsw_pixel_if.sink                       pixel,
    rpsw_result_if.source                    result
);
    import rpsw_pkg::*;

    cmd_t    cmd;
    status_t status;

    rpsw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    rpsw_datapath #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .pixel     (pixel),
        .result    (result)
    );
endmodule
